[design/ssem_pkg.sv]
// Shared types and constants for the SSEM instruction step unit.
// No dependencies; imported by every module of the block.
package ssem_pkg;

    localparam int STORE_WORDS = 32;
    localparam int LINE_W      = $clog2(STORE_WORDS);
    localparam int WORD_W      = 32;
    localparam int OP_W        = 3;
    localparam int OP_LSB      = 13;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_STEP  = 2'd2,
        ACT_SETCC = 2'd3
    } t_action;

    typedef enum logic [OP_W-1:0] {
        OP_JMP  = 3'd0,
        OP_JRP  = 3'd1,
        OP_LDN  = 3'd2,
        OP_STO  = 3'd3,
        OP_SUB  = 3'd4,
        OP_SUB2 = 3'd5,
        OP_CMP  = 3'd6,
        OP_STP  = 3'd7
    } t_opcode;

    typedef struct packed {
        t_action             action;
        logic [LINE_W-1:0]   address;
        logic [WORD_W-1:0]   data;
    } t_item;

    typedef struct packed {
        logic                en;
        logic                we;
        logic [LINE_W-1:0]   addr;
        logic [WORD_W-1:0]   wdata;
    } t_mem_req;

    typedef struct packed {
        logic                stopped;
        logic [OP_W-1:0]     opcode;
        logic [WORD_W-1:0]   counter;
        logic signed [WORD_W-1:0] acc;
        logic [WORD_W-1:0]   read_data;
    } t_result;

endpackage

[design/ssem_store.sv]
// Main store: single-port synchronous RAM with a registered read.
// Depends on ssem_pkg. Per-word valid bits make unwritten words read as zero.
module ssem_store
    import ssem_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_mem_req            i_req,
    output logic [WORD_W-1:0]   o_rdata
);

    logic [WORD_W-1:0]      r_mem [STORE_WORDS];
    logic [STORE_WORDS-1:0] r_vld;
    logic [WORD_W-1:0]      r_rdata;
    logic                   r_rvld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.en && i_req.we) begin
            r_vld[i_req.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            if (i_req.we) begin
                r_mem[i_req.addr] <= i_req.wdata;
            end else begin
                r_rdata <= r_mem[i_req.addr];
                r_rvld  <= r_vld[i_req.addr];
            end
        end
    end

    // read data holds until the next read
    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

[design/ssem_core.sv]
// Sequencer and machine registers (counter, accumulator, halt) with result register.
// Depends on ssem_pkg; drives the store port of ssem_store.
module ssem_core
    import ssem_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_item_valid,
    input  t_item               i_item,
    output logic                o_take,
    output t_mem_req            o_req,
    input  logic [WORD_W-1:0]   i_rdata,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_result             o_out
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_INSTR,
        ST_OPER
    } t_state;

    t_state              r_state, n_state;
    logic [WORD_W-1:0]   r_pc, n_pc;
    logic [WORD_W-1:0]   r_acc, n_acc;
    logic                r_halt, n_halt;
    t_opcode             r_op, n_op;
    logic                r_out_valid;
    t_result             r_out;

    logic                slot_free;
    logic                emit;
    logic [WORD_W-1:0]   res_rd;
    t_opcode             res_op;
    t_opcode             dec_op;

    assign slot_free = !r_out_valid || i_out_ready;
    assign dec_op    = t_opcode'(i_rdata[OP_LSB +: OP_W]);

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_acc   = r_acc;
        n_halt  = r_halt;
        n_op    = r_op;
        o_req   = '0;
        o_take  = 1'b0;
        emit    = 1'b0;
        res_rd  = '0;
        res_op  = OP_JMP;
        case (r_state)
            ST_IDLE: begin
                if (i_item_valid && slot_free) begin
                    o_take = 1'b1;
                    case (i_item.action)
                        ACT_WRITE: begin
                            o_req.en    = 1'b1;
                            o_req.we    = 1'b1;
                            o_req.addr  = i_item.address;
                            o_req.wdata = i_item.data;
                            emit        = 1'b1;
                        end
                        ACT_READ: begin
                            o_req.en   = 1'b1;
                            o_req.addr = i_item.address;
                            n_state    = ST_READ;
                        end
                        ACT_STEP: begin
                            if (r_halt) begin
                                emit = 1'b1;
                            end else begin
                                n_pc       = r_pc + 1'b1;
                                o_req.en   = 1'b1;
                                o_req.addr = n_pc[LINE_W-1:0];
                                n_state    = ST_INSTR;
                            end
                        end
                        default: begin
                            n_pc   = i_item.data;
                            n_halt = 1'b0;
                            emit   = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (slot_free) begin
                    res_rd = i_rdata;
                    emit   = 1'b1;
                end
            end
            ST_INSTR: begin
                // instruction word on i_rdata
                if (slot_free) begin
                    n_op   = dec_op;
                    res_op = dec_op;
                    case (dec_op)
                        OP_STO: begin
                            o_req.en    = 1'b1;
                            o_req.we    = 1'b1;
                            o_req.addr  = i_rdata[LINE_W-1:0];
                            o_req.wdata = r_acc;
                            emit        = 1'b1;
                        end
                        OP_CMP: begin
                            if (r_acc[WORD_W-1]) begin
                                n_pc = r_pc + 1'b1;
                            end
                            emit = 1'b1;
                        end
                        OP_STP: begin
                            n_halt = 1'b1;
                            emit   = 1'b1;
                        end
                        default: begin
                            o_req.en   = 1'b1;
                            o_req.addr = i_rdata[LINE_W-1:0];
                            n_state    = ST_OPER;
                        end
                    endcase
                end
            end
            ST_OPER: begin
                // operand word on i_rdata
                if (slot_free) begin
                    res_op = r_op;
                    emit   = 1'b1;
                    case (r_op)
                        OP_JMP:  n_pc  = i_rdata;
                        OP_JRP:  n_pc  = r_pc + i_rdata;
                        OP_LDN:  n_acc = '0 - i_rdata;
                        default: n_acc = r_acc - i_rdata;
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (emit) begin
            n_state = ST_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pc        <= '0;
            r_acc       <= '0;
            r_halt      <= 1'b0;
            r_op        <= OP_JMP;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_acc   <= n_acc;
            r_halt  <= n_halt;
            r_op    <= n_op;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.read_data <= res_rd;
            r_out.acc       <= n_acc;
            r_out.counter   <= n_pc;
            r_out.opcode    <= res_op;
            r_out.stopped   <= n_halt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[design/ssem_instruction_step_unit.sv]
// SSEM instruction step unit: top level, input buffer and stream ports.
// Depends on ssem_pkg, ssem_store and ssem_core.
//
// Small-scale experimental machine core with a 32 x 32-bit store, a 32-bit
// control counter, a 32-bit two's-complement accumulator and a halt flag.
// Each input transfer carries an action in s_axis_tuser: write a store word,
// read a store word, execute one instruction, or load the control counter
// (which also clears halt). Every input transfer gives exactly one output
// transfer holding the read word (zero unless a read), the accumulator,
// the counter, the opcode executed (zero for loader actions and for a step
// refused while halted) and the halt flag. A step first bumps the counter,
// fetches the word at its low five bits, then runs JMP/JRP/LDN/STO/SUB/CMP/STP
// with wrapping arithmetic. Store words read as zero until written; no
// clearing pass is needed after reset. Timing: everything goes through the
// single-port store, one access per cycle, with registered read data.
// A store write, a counter load or a refused step needs no store read; a
// store read, STO, CMP and STP wait for one read; JMP, JRP, LDN and SUB
// do instruction fetch, operand read, execute. A one-entry input buffer and
// a result register let a new item be taken while the previous result waits.
module ssem_instruction_step_unit
    import ssem_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave side
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,   // [4:0] address, [36:5] data, [39:37] zero
    input  logic [1:0]   s_axis_tuser,   // [1:0] action
    // master side
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata    // [31:0] read_data, [63:32] accumulator_value,
                                         // [95:64] counter_value, [98:96] executed_opcode,
                                         // [99] stopped, [103:100] zero
);

    logic      r_buf_valid;
    t_item     r_buf;
    logic      take;
    t_mem_req  mem_req;
    logic [WORD_W-1:0] mem_rdata;
    logic      out_valid;
    t_result   out_res;

    // buffer frees in the same cycle the core takes it
    assign s_axis_tready = !r_buf_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_buf_valid <= 1'b1;
        end else if (take) begin
            r_buf_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_buf.action  <= t_action'(s_axis_tuser);
            r_buf.address <= s_axis_tdata[LINE_W-1:0];
            r_buf.data    <= s_axis_tdata[LINE_W +: WORD_W];
        end
    end

    ssem_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    ssem_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (r_buf_valid),
        .i_item       (r_buf),
        .o_take       (take),
        .o_req        (mem_req),
        .i_rdata      (mem_rdata),
        .o_out_valid  (out_valid),
        .i_out_ready  (m_axis_tready),
        .o_out        (out_res)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {4'b0000, out_res.stopped, out_res.opcode, out_res.counter,
                            out_res.acc, out_res.read_data};

endmodule

[bench/tb_top.sv]
// Self-checking bench for ssem_instruction_step_unit: drives stream transfers and
// checks each result against a built-in model of the machine. Depends on ssem_pkg.
`timescale 1ns / 100ps

module tb_top;
    import ssem_pkg::*;

    // Watchdog: cycles in a row with no transfer on either side. The slowest
    // item's time in the block plus a sender gap and a receiver stall stays
    // far below this limit, so it leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 500;
    // Quiet cycles after the last result.
    localparam int TAIL_CYCLES    = 16;
    localparam int PRINT_CAP      = 40;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata = '0;    // [4:0] address, [36:5] data, [39:37] zero
    logic [1:0]   s_axis_tuser = '0;    // [1:0] action
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;         // [31:0] read_data, [63:32] accumulator,
                                        // [95:64] counter, [98:96] opcode,
                                        // [99] stopped, [103:100] zero

    ssem_instruction_step_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Machine model: shadow copy of store, control counter (CI),
    // accumulator and halt flag, updated at each accepted input transfer.
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] shadow_store [STORE_WORDS];
    logic [WORD_W-1:0] shadow_ci;
    logic [WORD_W-1:0] shadow_acc;
    logic              shadow_halt;

    t_result pending_results[$];        // expected results, oldest first

    int mismatch_count = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int refused_steps  = 0;
    int op_count [8];

    // Sender burst state; gaps can be turned off for stretches.
    int burst_left   = 0;
    bit sender_gaps  = 1'b1;

    // Computes the result of one item and advances the shadow machine.
    function automatic t_result ssem_next_result(input t_action act,
                                                 input logic [LINE_W-1:0] line,
                                                 input logic [WORD_W-1:0] word);
        t_result           r;
        logic [WORD_W-1:0] instr;
        logic [LINE_W-1:0] s;
        t_opcode           op;
        r = '0;
        case (act)
            ACT_WRITE: shadow_store[line] = word;
            ACT_READ:  r.read_data = shadow_store[line];
            ACT_STEP: begin
                if (shadow_halt) begin
                    refused_steps++;        // halted: nothing moves, opcode stays zero
                end else begin
                    shadow_ci = shadow_ci + 1;
                    // fetch uses the counter's low bits; CI itself keeps 32 bits
                    instr = shadow_store[shadow_ci[LINE_W-1:0]];
                    s     = instr[LINE_W-1:0];
                    op    = t_opcode'(instr[OP_LSB +: OP_W]);
                    case (op)
                        OP_JMP:          shadow_ci  = shadow_store[s];
                        OP_JRP:          shadow_ci  = shadow_ci + shadow_store[s];
                        OP_LDN:          shadow_acc = '0 - shadow_store[s];
                        OP_STO:          shadow_store[s] = shadow_acc;
                        OP_SUB, OP_SUB2: shadow_acc = shadow_acc - shadow_store[s];
                        OP_CMP:          if (shadow_acc[WORD_W-1]) shadow_ci = shadow_ci + 1;
                        default:         shadow_halt = 1'b1;
                    endcase
                    r.opcode = op;
                    op_count[op]++;
                end
            end
            default: begin
                shadow_ci   = word;         // counter load also clears halt
                shadow_halt = 1'b0;
            end
        endcase
        r.acc     = shadow_acc;
        r.counter = shadow_ci;
        r.stopped = shadow_halt;
        return r;
    endfunction

    // Instruction word; noisy fills the unused bits so decoding must ignore them.
    function automatic logic [WORD_W-1:0] make_instr(input t_opcode op,
                                                     input logic [LINE_W-1:0] s,
                                                     input bit noisy);
        logic [WORD_W-1:0] w;
        w = noisy ? $urandom : '0;
        w[LINE_W-1:0]       = s;
        w[OP_LSB +: OP_W]   = op;
        return w;
    endfunction

    // Data word biased toward the arithmetic corners.
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return $urandom_range(0, 40);
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("ERROR @%0t result %0d %s: got %h, expected %h",
                     $realtime, results_seen, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Sender: one item per call, in bursts with random gaps. Always
    // entered and left at a rising edge, so valid stays high across
    // back-to-back items and gets one assignment per edge.
    // ------------------------------------------------------------------
    task automatic send_item(input t_action act, input logic [LINE_W-1:0] line,
                             input logic [WORD_W-1:0] word);
        int gap;
        if (burst_left == 0) begin
            gap = sender_gaps ? $urandom_range(0, 6) : 0;
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, word, line};
        s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(ssem_next_result(act, line, word));
        items_sent++;
    endtask

    // Sender holds off until every expected result has come back.
    task automatic drain_pending();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: ready pattern that changes each time the 8-bit phase counter wraps,
    // between always ready, coin flip, periodic and long stalls.
    // ------------------------------------------------------------------
    logic [7:0] stall_phase = '0;
    logic [1:0] stall_mode  = '0;

    always @(posedge i_clk) begin : ready_gen
        logic rdy;
        case (stall_mode)
            2'd0:    rdy = 1'b1;
            2'd1:    rdy = 1'($urandom_range(0, 1));
            2'd2:    rdy = (stall_phase % 3) == 0;
            default: rdy = stall_phase[4:3] != 2'b11;
        endcase
        m_axis_tready <= rdy;
        stall_phase   <= stall_phase + 8'd1;
        if (stall_phase == 8'hFF) stall_mode <= 2'($urandom_range(0, 3));
    end

    // ------------------------------------------------------------------
    // Result check: each output transfer against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[99:0]);
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with none expected", got.counter, '0);
            end else begin
                want = pending_results.pop_front();
                if (got.read_data !== want.read_data)
                    report_mismatch("read_data", got.read_data, want.read_data);
                if (got.acc !== want.acc)
                    report_mismatch("accumulator", got.acc, want.acc);
                if (got.counter !== want.counter)
                    report_mismatch("counter", got.counter, want.counter);
                if (got.opcode !== want.opcode)
                    report_mismatch("opcode", 32'(got.opcode), 32'(want.opcode));
                if (got.stopped !== want.stopped)
                    report_mismatch("stopped", 32'(got.stopped), 32'(want.stopped));
                if (m_axis_tdata[103:100] !== 4'b0000)
                    report_mismatch("padding", 32'(m_axis_tdata[103:100]), '0);
            end
        end
    end

    // Watchdog on stalled traffic.
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Store lines at both ends, all-ones data, and a never-written line (reads zero).
    task automatic test_store_lines();
        send_item(ACT_WRITE, 5'd31, 32'hFFFF_FFFF);
        send_item(ACT_READ,  5'd31, 32'h0);
        send_item(ACT_READ,  5'd0,  32'hFFFF_FFFF);
    endtask

    // Short program touching every opcode, the CMP skip, a JMP far past the
    // store, STP, a step refused while halted, and a read that keeps halt.
    task automatic test_opcodes_directed();
        send_item(ACT_WRITE, 5'd20, 32'd5);
        send_item(ACT_WRITE, 5'd21, 32'd3);
        send_item(ACT_WRITE, 5'd25, 32'hFFFF_FFFE);
        send_item(ACT_WRITE, 5'd1,  make_instr(OP_LDN,  5'd20, 1'b0));
        send_item(ACT_WRITE, 5'd2,  make_instr(OP_SUB,  5'd21, 1'b0));
        send_item(ACT_WRITE, 5'd3,  make_instr(OP_SUB2, 5'd20, 1'b1));
        send_item(ACT_WRITE, 5'd4,  make_instr(OP_CMP,  5'd0,  1'b1));  // acc < 0: skip line 5
        send_item(ACT_WRITE, 5'd6,  make_instr(OP_STO,  5'd22, 1'b1));
        send_item(ACT_WRITE, 5'd7,  make_instr(OP_JRP,  5'd21, 1'b0));  // CI 7 -> 10
        send_item(ACT_WRITE, 5'd11, make_instr(OP_JMP,  5'd25, 1'b1));  // CI -> FFFFFFFE
        send_item(ACT_WRITE, 5'd31, make_instr(OP_STP,  5'd9,  1'b1));  // fetched at CI FFFFFFFF
        send_item(ACT_SETCC, 5'd0,  32'h0);
        repeat (8) send_item(ACT_STEP, LINE_W'($urandom), $urandom);
        send_item(ACT_STEP,  5'd0,  32'h0);                             // refused, halted
        send_item(ACT_READ,  5'd22, 32'h0);                             // halt stays set
        drain_pending();
        send_item(ACT_SETCC, 5'd0,  32'hFFFF_FFFF);                     // clears halt
        send_item(ACT_STEP,  5'd0,  32'h0);                             // CI wraps to 0
    endtask

    // Random programs: load a few instructions after a random origin, some
    // operand words, point CI at the origin (often with high bits set),
    // then run until STP or a step budget runs out.
    task automatic test_programs_random(input int n_items);
        int                start_count;
        int                len;
        int                steps;
        logic [LINE_W-1:0] origin;
        t_opcode           op;
        start_count = items_sent;
        while (items_sent - start_count < n_items) begin
            sender_gaps = $urandom_range(0, 3) != 0;
            origin = LINE_W'($urandom);
            len    = $urandom_range(1, 8);
            for (int i = 1; i <= len; i++) begin
                op = ($urandom_range(0, 15) == 0) ? OP_STP : t_opcode'($urandom_range(0, 6));
                send_item(ACT_WRITE, origin + i[LINE_W-1:0],
                          make_instr(op, LINE_W'($urandom), 1'($urandom_range(0, 1))));
            end
            repeat ($urandom_range(1, 3)) send_item(ACT_WRITE, LINE_W'($urandom), pick_word());
            send_item(ACT_SETCC, LINE_W'($urandom),
                      {($urandom_range(0, 3) == 0) ? 27'($urandom) : 27'd0, origin});
            steps = $urandom_range(1, 14);
            while (steps > 0 && !shadow_halt) begin
                send_item(ACT_STEP, LINE_W'($urandom), $urandom);
                steps--;
            end
            if ($urandom_range(0, 2) == 0) send_item(ACT_STEP, LINE_W'($urandom), $urandom);
            if ($urandom_range(0, 2) == 0) send_item(ACT_READ, LINE_W'($urandom), $urandom);
            // hold-off until the pipeline is empty, now and then
            if ($urandom_range(0, 19) == 0) drain_pending();
        end
    endtask

    // Unstructured traffic: any action, any line, any word.
    task automatic test_noise_random(input int n_items);
        sender_gaps = 1'b1;
        repeat (n_items)
            send_item(t_action'($urandom_range(0, 3)), LINE_W'($urandom),
                      ($urandom_range(0, 1) != 0) ? $urandom : pick_word());
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        foreach (shadow_store[i]) shadow_store[i] = '0;
        foreach (op_count[i]) op_count[i] = 0;
        shadow_ci   = '0;
        shadow_acc  = '0;
        shadow_halt = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_store_lines();
        test_opcodes_directed();
        test_programs_random(1500);
        test_noise_random(420);

        // let everything come back, then TAIL_CYCLES quiet cycles
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (pending_results.size() != 0)
            report_mismatch("results never arrived", pending_results.size(), '0);

        $display("Covered %0d input transfers, %0d results checked, %0d steps refused while halted",
                 items_sent, results_seen, refused_steps);
        $display("Steps run: JMP %0d JRP %0d LDN %0d STO %0d SUB %0d/%0d CMP %0d STP %0d",
                 op_count[0], op_count[1], op_count[2], op_count[3],
                 op_count[4], op_count[5], op_count[6], op_count[7]);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
